### rtl/qlla_pkg.sv
package qlla_pkg;

  localparam int NumStates     = 72;
  localparam int NumActions    = 5;
  localparam int TableDepth    = NumStates * NumActions;
  localparam int TableAw       = 9;
  localparam int LaneWidth     = 64;
  localparam int StatesPerLane = 24;
  localparam logic [6:0] ResetState = 7'd25;

  typedef enum logic [2:0] {
    ActFaster = 3'd0,
    ActSlower = 3'd1,
    ActLeft   = 3'd2,
    ActRight  = 3'd3,
    ActKeep   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    RegSafety   = 3'd0,
    RegSpeedLim = 3'd1,
    RegMinSpeed = 3'd2,
    RegGain     = 3'd3,
    RegLrate    = 3'd4,
    RegDiscount = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    StClear,
    StIdle,
    StRdAct,
    StCmp,
    StRdOld,
    StMul1,
    StMul2,
    StWrite,
    StOut
  } state_e;

  // frame descriptor handed from front to back
  typedef struct packed {
    logic [6:0]  state_number;
    logic [4:0]  allowed;
    logic [19:0] reward;
  } frame_t;

  typedef struct packed {
    logic [14:0] safety_distance;
    logic [10:0] fast_speed;
    logic [10:0] slow_speed;
    logic [15:0] speed_reward_gain;
    logic [15:0] learning_rate;
    logic [15:0] discount;
  } cfg_t;

endpackage

### rtl/qlla_if.sv
interface qlla_in_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic        kind;
  logic [9:0]  lateral_offset;
  logic [15:0] gap;
  logic [10:0] ego_speed;
  modport source (output valid, kind, lateral_offset, gap, ego_speed, input ready);
  modport sink (input valid, kind, lateral_offset, gap, ego_speed, output ready);
endinterface

interface qlla_out_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  state_number;
  logic [19:0] reward;
  logic [31:0] updated_value;
  modport source (output valid, action, state_number, reward, updated_value, input ready);
  modport sink (input valid, action, state_number, reward, updated_value, output ready);
endinterface

interface qlla_cfg_if (input logic clk_i);
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/q_learning_lane_agent_top.sv
// Lane-choice agent with a 360-entry Q-value table.
// in_if: car reports (kind 0) set lane occupancy flags and give no result;
//   a frame item (kind 1) gives one result on out_if.
// cfg_if: register writes by index, always ready; write only when idle.
// Car reports are taken every cycle. A frame passes the front in the cycle
// it is accepted into a two-entry queue; the back takes it from the queue
// when idle and then runs its steps: five table reads with compares for the
// action scan (a read state and a compare state each, one read port), a
// read of the past entry, two dependent multiply stages, a write-back and
// the result state. The back takes no new frame until its result has been
// taken; the queue holds up to two frames meanwhile.
// A result holds on out_if until taken; while stalled the queue fills and
// then frame items are held off, car reports still pass.
// Reset: registers return to their defaults and a clearing pass writes
// zero to all 360 table entries before the first frame runs.
module q_learning_lane_agent_top (
  input logic clk_i,
  input logic rst_ni,
  qlla_in_if.sink    in_if,
  qlla_cfg_if.sink   cfg_if,
  qlla_out_if.source out_if
);

  qlla_pkg::cfg_t   cfg_q;
  qlla_pkg::frame_t fw, fr;
  logic fw_v, fw_r, fr_v, fr_r;

  assign cfg_if.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safety_distance   <= 15'd480;
      cfg_q.fast_speed        <= 11'd720;
      cfg_q.slow_speed        <= 11'd160;
      cfg_q.speed_reward_gain <= 16'd91;
      cfg_q.learning_rate     <= 16'd6554;
      cfg_q.discount          <= 16'd62259;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        qlla_pkg::RegSafety:   cfg_q.safety_distance   <= cfg_if.data[14:0];
        qlla_pkg::RegSpeedLim: cfg_q.fast_speed        <= cfg_if.data[10:0];
        qlla_pkg::RegMinSpeed: cfg_q.slow_speed        <= cfg_if.data[10:0];
        qlla_pkg::RegGain:     cfg_q.speed_reward_gain <= cfg_if.data[15:0];
        qlla_pkg::RegLrate:    cfg_q.learning_rate     <= cfg_if.data[15:0];
        qlla_pkg::RegDiscount: cfg_q.discount          <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  qlla_front u_front (.clk_i, .rst_ni, .in_if, .cfg_i(cfg_q),
    .fr_valid_o(fw_v), .fr_ready_i(fw_r), .fr_o(fw));

  qlla_fifo u_fifo (.clk_i, .rst_ni, .wr_valid_i(fw_v), .wr_ready_o(fw_r),
    .wr_data_i(fw), .rd_valid_o(fr_v), .rd_ready_i(fr_r), .rd_data_o(fr));

  qlla_back u_back (.clk_i, .rst_ni, .cfg_i(cfg_q), .fr_valid_i(fr_v),
    .fr_ready_o(fr_r), .fr_i(fr), .out_if);

endmodule

### rtl/qlla_front.sv
module qlla_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  qlla_in_if.sink              in_if,
  input  qlla_pkg::cfg_t       cfg_i,
  output logic                 fr_valid_o,
  input  logic                 fr_ready_i,
  output qlla_pkg::frame_t     fr_o
);

  logic [2:0] busy_q, busy_d;
  logic       acc;
  logic [1:0] lane;
  logic [1:0] cls;
  logic [4:0] allowed;
  logic [6:0] st;
  logic signed [20:0] rw;
  logic [26:0] term;
  logic [16:0] term_sat;
  logic        hit;
  logic [9:0]  offs;
  logic signed [15:0] gap;

  assign offs  = in_if.lateral_offset;
  assign gap   = in_if.gap;
  // car reports always accepted; frames need queue room
  assign in_if.ready = in_if.kind ? fr_ready_i : 1'b1;
  assign acc = in_if.valid && in_if.ready;

  // classification
  always_comb begin
    lane = (offs >= 10'd128) ? 2'd2 : ((offs >= 10'd64) ? 2'd1 : 2'd0);
    if (in_if.ego_speed >= cfg_i.fast_speed) cls = 2'd2;
    else if (in_if.ego_speed <= cfg_i.slow_speed) cls = 2'd0;
    else cls = 2'd1;
    st = 7'(lane) * 7'd24 + (busy_q[0] ? 7'd12 : 7'd0) + (busy_q[1] ? 7'd6 : 7'd0)
         + (busy_q[2] ? 7'd3 : 7'd0) + {5'd0, cls};
    allowed = '0;
    if (lane == 2'd0 && !busy_q[1]) allowed[qlla_pkg::ActRight] = 1'b1;
    if (lane == 2'd1) begin
      if (!busy_q[2]) allowed[qlla_pkg::ActRight] = 1'b1;
      if (!busy_q[0]) allowed[qlla_pkg::ActLeft] = 1'b1;
    end
    if (lane == 2'd2 && !busy_q[1]) allowed[qlla_pkg::ActLeft] = 1'b1;
    if (cls == 2'd0) allowed[qlla_pkg::ActFaster] = 1'b1;
    else if (cls == 2'd2) allowed[qlla_pkg::ActSlower] = 1'b1;
    else begin
      allowed[qlla_pkg::ActFaster] = 1'b1;
      allowed[qlla_pkg::ActSlower] = 1'b1;
      allowed[qlla_pkg::ActKeep]   = 1'b1;
    end
    term = in_if.ego_speed * cfg_i.speed_reward_gain;
    term_sat = (term > 27'd65536) ? 17'd65536 : term[16:0];
    rw = (cls == 2'd1) ? 21'sd65536 + $signed({4'd0, term_sat}) : 21'sd0;
    rw = busy_q[lane] ? rw - 21'sd131072 : rw + 21'sd131072;
  end

  // lane occupancy flags
  always_comb begin
    busy_d = busy_q;
    hit = (gap > 16'sd0) && (gap < $signed({1'b0, cfg_i.safety_distance}));
    if (acc && !in_if.kind && hit) begin
      if (offs > 10'd64 && offs < 10'd128) busy_d[1] = 1'b1;
      else if (offs > 10'd0 && offs < 10'd64) busy_d[0] = 1'b1;
      else if (offs > 10'd128 && offs < 10'd192) busy_d[2] = 1'b1;
    end
    if (acc && in_if.kind) busy_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_q <= '0;
    else busy_q <= busy_d;
  end

  assign fr_valid_o = acc && in_if.kind;
  assign fr_o.state_number = st;
  assign fr_o.allowed = allowed;
  assign fr_o.reward = rw[19:0];

endmodule

### rtl/qlla_fifo.sv
module qlla_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  qlla_pkg::frame_t wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output qlla_pkg::frame_t rd_data_o
);

  qlla_pkg::frame_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

endmodule

### rtl/qlla_back.sv
module qlla_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qlla_pkg::cfg_t   cfg_i,
  input  logic             fr_valid_i,
  output logic             fr_ready_o,
  input  qlla_pkg::frame_t fr_i,
  qlla_out_if.source       out_if
);

  qlla_pkg::state_e state_q, state_d;
  logic signed [31:0] mem [qlla_pkg::TableDepth];
  logic [qlla_pkg::TableAw-1:0] raddr, waddr, clr_q;
  logic signed [31:0] rdata_q;
  logic        we;
  logic signed [31:0] wdata;

  qlla_pkg::frame_t fr_q;
  logic [6:0] pst_q;
  logic [2:0] pact_q;
  logic [2:0] a_q, a_d;
  logic [2:0] best_a_q, best_a_d;
  logic       found_q, found_d;
  logic signed [31:0] best_q, best_d;
  logic signed [31:0] old_q;
  logic signed [49:0] prod1_q;
  logic signed [34:0] target;
  logic signed [52:0] prod2_q;
  logic signed [36:0] nv;
  logic signed [31:0] nv_sat;
  logic signed [31:0] nv_sat_q;
  logic        clr_done;

  // table RAM, one read and one write port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign clr_done = clr_q == 9'(qlla_pkg::TableDepth - 1);

  always_comb begin
    state_d = state_q;
    a_d = a_q;
    best_a_d = best_a_q;
    found_d = found_q;
    best_d = best_q;
    we = 1'b0;
    waddr = clr_q;
    wdata = '0;
    raddr = 9'(fr_q.state_number * 9'd5) + {6'd0, a_q};
    fr_ready_o = 1'b0;
    case (state_q)
      qlla_pkg::StClear: begin
        we = 1'b1;
        if (clr_done) state_d = qlla_pkg::StIdle;
      end
      qlla_pkg::StIdle: begin
        fr_ready_o = 1'b1;
        a_d = '0;
        found_d = 1'b0;
        best_d = '0;
        best_a_d = '0;
        if (fr_valid_i) state_d = qlla_pkg::StRdAct;
      end
      // issue a read for every action in turn, the next one after the compare of the last
      qlla_pkg::StRdAct: state_d = qlla_pkg::StCmp;
      qlla_pkg::StCmp: begin
        if (fr_q.allowed[a_q] && (!found_q || rdata_q > best_q)) begin
          found_d = 1'b1;
          best_d = rdata_q;
          best_a_d = a_q;
        end
        if (a_q == 3'(qlla_pkg::NumActions - 1)) begin
          state_d = qlla_pkg::StRdOld;
        end else begin
          a_d = a_q + 3'd1;
          state_d = qlla_pkg::StRdAct;
        end
      end
      qlla_pkg::StRdOld: begin
        raddr = 9'(pst_q * 9'd5) + {6'd0, pact_q};
        state_d = qlla_pkg::StMul1;
      end
      qlla_pkg::StMul1: state_d = qlla_pkg::StMul2;
      qlla_pkg::StMul2: state_d = qlla_pkg::StWrite;
      qlla_pkg::StWrite: begin
        we = 1'b1;
        waddr = 9'(pst_q * 9'd5) + {6'd0, pact_q};
        wdata = nv_sat;
        state_d = qlla_pkg::StOut;
      end
      qlla_pkg::StOut: if (out_if.ready) state_d = qlla_pkg::StIdle;
      default: state_d = qlla_pkg::StIdle;
    endcase
  end

  assign target = 35'($signed(fr_q.reward)) + 35'(prod1_q >>> 16);
  assign nv = 37'(old_q) + 37'(prod2_q >>> 16);

  // saturate new value to 32 bit signed
  always_comb begin
    if (nv > 37'sd2147483647) nv_sat = 32'sh7fffffff;
    else if (nv < -37'sd2147483648) nv_sat = 32'sh80000000;
    else nv_sat = nv[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (fr_ready_o && fr_valid_i) fr_q <= fr_i;
    if (state_q == qlla_pkg::StMul1) begin
      old_q <= rdata_q;
      prod1_q <= $signed({1'b0, cfg_i.discount}) * best_q;
    end
    if (state_q == qlla_pkg::StMul2)
      prod2_q <= $signed({1'b0, cfg_i.learning_rate}) * (36'(target) - 36'(old_q));
    if (state_q == qlla_pkg::StWrite) nv_sat_q <= nv_sat;
  end

  // sequencer state, clear pointer and past state/action
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qlla_pkg::StClear;
      clr_q <= '0;
      a_q <= '0;
      best_a_q <= '0;
      found_q <= 1'b0;
      best_q <= '0;
      pst_q <= qlla_pkg::ResetState;
      pact_q <= '0;
    end else begin
      state_q <= state_d;
      a_q <= a_d;
      best_a_q <= best_a_d;
      found_q <= found_d;
      best_q <= best_d;
      if (state_q == qlla_pkg::StClear && !clr_done) clr_q <= clr_q + 9'd1;
      if (state_q == qlla_pkg::StWrite) begin
        pst_q <= fr_q.state_number;
        pact_q <= best_a_q;
      end
    end
  end

  assign out_if.valid = state_q == qlla_pkg::StOut;
  assign out_if.action = best_a_q;
  assign out_if.state_number = pst_q;
  assign out_if.reward = fr_q.reward;
  assign out_if.updated_value = nv_sat_q;

endmodule

### rtl/qlla_checker.sv
module qlla_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] action_i,
  input logic [6:0] state_number_i,
  input logic       cfg_ready_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(action_i)) else $error("out drop");
  a_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> action_i <= 3'd4) else $error("bad action");
  a_st: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> state_number_i < 7'd72) else $error("bad state");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i) else $error("cfg stall");

endmodule

bind q_learning_lane_agent_top qlla_checker u_chk (.clk_i, .rst_ni,
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready), .action_i(out_if.action),
  .state_number_i(out_if.state_number), .cfg_ready_i(cfg_if.ready));

### tb/q_learning_lane_agent_top_tb.sv
module q_learning_lane_agent_top_tb;

  logic clk_i;
  logic rst_ni;

  qlla_in_if  in_if  (clk_i);
  qlla_out_if out_if (clk_i);
  qlla_cfg_if cfg_if (clk_i);

  q_learning_lane_agent_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .out_if (out_if)
  );

  typedef struct packed {
    logic        kind;
    logic [9:0]  offs;
    logic [15:0] gap;
    logic [10:0] speed;
  } lane_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [6:0]  state_number;
    logic [19:0] reward;
    logic [31:0] updated_value;
  } decision_t;

  localparam int DrainCycles = 40;
  localparam logic [2:0] UnusedReg = 3'd6;

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  lane_item_t pending_items[$];
  decision_t  expected_decisions[$];

  // shadow of the block state and registers
  int              q_table[qlla_pkg::TableDepth];
  logic [2:0]      busy_lanes;
  logic [6:0]      last_state;
  logic [2:0]      last_act;
  qlla_pkg::cfg_t  cfg;

  int  send_idle_pct, recv_idle_pct;
  bit  hold_send, hold_recv;
  bit  in_fire;
  int  errors, frames_seen, cars_seen, results_seen;

  function automatic longint floor16(longint x);
    return x >>> 16;
  endfunction

  function automatic void add_item(lane_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  // applies one accepted item to the shadow state
  function automatic void predict_decision(lane_item_t it);
    int         g, lane, cls, st, best, idx;
    logic [4:0] allowed;
    bit         found;
    logic [2:0] act;
    longint     rwd, term, old, target, nv;
    decision_t  d;
    if (!it.kind) begin
      g = $signed(it.gap);
      if (g > 0 && g < int'(cfg.safety_distance)) begin
        if (it.offs > qlla_pkg::LaneWidth && it.offs < 2 * qlla_pkg::LaneWidth)
          busy_lanes[1] = 1'b1;
        else if (it.offs > 0 && it.offs < qlla_pkg::LaneWidth)
          busy_lanes[0] = 1'b1;
        else if (it.offs > 2 * qlla_pkg::LaneWidth && it.offs < 3 * qlla_pkg::LaneWidth)
          busy_lanes[2] = 1'b1;
      end
      cars_seen++;
      return;
    end
    frames_seen++;
    lane = it.offs / qlla_pkg::LaneWidth;
    if (lane > 2) lane = 2;
    cls = (it.speed >= cfg.fast_speed) ? 2 : ((it.speed <= cfg.slow_speed) ? 0 : 1);
    st = lane * qlla_pkg::StatesPerLane + busy_lanes[0] * 12 + busy_lanes[1] * 6
         + busy_lanes[2] * 3 + cls;
    allowed = '0;
    if (lane == 0 && !busy_lanes[1]) allowed[qlla_pkg::ActRight] = 1'b1;
    if (lane == 1) begin
      if (!busy_lanes[2]) allowed[qlla_pkg::ActRight] = 1'b1;
      if (!busy_lanes[0]) allowed[qlla_pkg::ActLeft] = 1'b1;
    end
    if (lane == 2 && !busy_lanes[1]) allowed[qlla_pkg::ActLeft] = 1'b1;
    if (cls == 0) allowed[qlla_pkg::ActFaster] = 1'b1;
    else if (cls == 2) allowed[qlla_pkg::ActSlower] = 1'b1;
    else begin
      allowed[qlla_pkg::ActFaster] = 1'b1;
      allowed[qlla_pkg::ActSlower] = 1'b1;
      allowed[qlla_pkg::ActKeep]   = 1'b1;
    end
    // greedy scan, lowest index wins ties
    found = 0; best = 0; act = qlla_pkg::ActFaster;
    for (int a = 0; a < qlla_pkg::NumActions; a++) begin
      if (allowed[a] && (!found || q_table[st * qlla_pkg::NumActions + a] > best)) begin
        found = 1;
        best  = q_table[st * qlla_pkg::NumActions + a];
        act   = a[2:0];
      end
    end
    rwd = 65536;
    if (cls != 1) rwd -= 65536;
    else begin
      term = longint'(it.speed) * longint'(cfg.speed_reward_gain);
      if (term > 65536) term = 65536;
      rwd += term;
    end
    if (busy_lanes[lane]) rwd -= 2 * 65536;
    else rwd += 2 * 65536;
    idx    = last_state * qlla_pkg::NumActions + last_act;
    old    = q_table[idx];
    target = rwd + floor16(longint'(cfg.discount) * longint'(best));
    nv     = old + floor16(longint'(cfg.learning_rate) * (target - old));
    if (nv > 64'sd2147483647) nv = 64'sd2147483647;
    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
    q_table[idx] = int'(nv);
    d.action        = act;
    d.state_number  = st[6:0];
    d.reward        = rwd[19:0];
    d.updated_value = nv[31:0];
    expected_decisions.insert(expected_decisions.size(), d);
    last_state = st[6:0];
    last_act   = act;
    busy_lanes = '0;
  endfunction

  // input side: sample at the rising edge
  always @(posedge clk_i) begin
    in_fire = in_if.valid && in_if.ready;
    if (in_fire)
      predict_decision({in_if.kind, in_if.lateral_offset, in_if.gap, in_if.ego_speed});
  end

  // driver: changes at the falling edge
  always @(negedge clk_i) begin
    if (!in_if.valid || in_fire) begin
      if (pending_items.size() > 0 && !hold_send && $urandom_range(99) >= send_idle_pct) begin
        {in_if.kind, in_if.lateral_offset, in_if.gap, in_if.ego_speed} <= pending_items[0];
        pending_items.pop_front();
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    decision_t got, exp_d;
    if (out_if.valid && out_if.ready) begin
      got = {out_if.action, out_if.state_number, out_if.reward, out_if.updated_value};
      results_seen++;
      if (expected_decisions.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        exp_d = expected_decisions.pop_front();
        if (got.action !== exp_d.action) begin
          errors++;
          $display("%0t: action exp %0d got %0d", $time, exp_d.action, got.action);
        end
        if (got.state_number !== exp_d.state_number) begin
          errors++;
          $display("%0t: state exp %0d got %0d", $time, exp_d.state_number,
                   got.state_number);
        end
        if (got.reward !== exp_d.reward) begin
          errors++;
          $display("%0t: reward exp %h got %h", $time, exp_d.reward, got.reward);
        end
        if (got.updated_value !== exp_d.updated_value) begin
          errors++;
          $display("%0t: value exp %h got %h", $time, exp_d.updated_value,
                   got.updated_value);
        end
      end
    end
  end

  // register write, shadow updated on acceptance
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      qlla_pkg::RegSafety:   cfg.safety_distance   = data[14:0];
      qlla_pkg::RegSpeedLim: cfg.fast_speed        = data[10:0];
      qlla_pkg::RegMinSpeed: cfg.slow_speed        = data[10:0];
      qlla_pkg::RegGain:     cfg.speed_reward_gain = data[15:0];
      qlla_pkg::RegLrate:    cfg.learning_rate     = data[15:0];
      qlla_pkg::RegDiscount: cfg.discount          = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] sd, logic [31:0] sl, logic [31:0] ms,
                           logic [31:0] gn, logic [31:0] lr, logic [31:0] dc);
    write_reg(qlla_pkg::RegSafety, sd);
    write_reg(qlla_pkg::RegSpeedLim, sl);
    write_reg(qlla_pkg::RegMinSpeed, ms);
    write_reg(qlla_pkg::RegGain, gn);
    write_reg(qlla_pkg::RegLrate, lr);
    write_reg(qlla_pkg::RegDiscount, dc);
  endtask

  // wait for everything queued to be taken and every result to arrive
  task automatic wait_idle();
    while (pending_items.size() > 0 || in_if.valid || expected_decisions.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic lane_item_t car(int offs, int gap);
    lane_item_t it;
    it.kind  = 1'b0;
    it.offs  = offs[9:0];
    it.gap   = gap[15:0];
    it.speed = 11'($urandom);
    return it;
  endfunction

  function automatic lane_item_t frame(int offs, int speed);
    lane_item_t it;
    it.kind  = 1'b1;
    it.offs  = offs[9:0];
    it.gap   = 16'($urandom);
    it.speed = speed[10:0];
    return it;
  endfunction

  // mostly well-formed frames: a few car reports then a frame
  task automatic queue_random(int n);
    int cnt, sd, k, offs;
    lane_item_t it;
    cnt = 0;
    sd = cfg.safety_distance;
    while (cnt < n) begin
      if ($urandom_range(9) == 0) begin
        {it.kind, it.offs, it.gap, it.speed} = 38'({$urandom, $urandom});
        add_item(it);
        cnt++;
      end else begin
        k = $urandom_range(5);
        repeat (k) begin
          case ($urandom_range(3))
            0: offs = $urandom_range(255);
            1: offs = 64 * $urandom_range(4) + $urandom_range(2) - 1;
            default: offs = $urandom_range(191);
          endcase
          case ($urandom_range(3))
            0: add_item(car(offs, sd + $urandom_range(4) - 2));
            1: add_item(car(offs, $urandom_range(4) - 2));
            2: add_item(car(offs, $signed(16'($urandom))));
            default: add_item(car(offs, $urandom_range(sd > 1 ? sd : 1)));
          endcase
          cnt++;
        end
        case ($urandom_range(3))
          0: k = cfg.fast_speed + $urandom_range(2) - 1;
          1: k = cfg.slow_speed + $urandom_range(2) - 1;
          default: k = $urandom_range(2047);
        endcase
        if (k < 0) k = 0;
        if (k > 2047) k = 2047;
        offs = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(191);
        add_item(frame(offs, k));
        cnt++;
      end
    end
  endtask

  // watchdog
  initial begin
    #8000000;
    $display("q_learning_lane_agent_top test failed");
    $finish;
  end

  initial begin
    errors = 0; frames_seen = 0; cars_seen = 0; results_seen = 0;
    hold_send = 0; hold_recv = 0; send_idle_pct = 0; recv_idle_pct = 0;
    in_fire = 0;
    in_if.valid = 1'b0; in_if.kind = 1'b0; in_if.lateral_offset = '0;
    in_if.gap = '0; in_if.ego_speed = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    foreach (q_table[i]) q_table[i] = 0;
    busy_lanes = '0; last_state = qlla_pkg::ResetState; last_act = qlla_pkg::ActFaster;
    cfg = '{15'd480, 11'd720, 11'd160, 16'd91, 16'd6554, 16'd62259};
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: lane bounds, gap bounds, speed classes
    add_item(car(32, 1));
    add_item(car(64, 100));
    add_item(frame(0, 0));
    add_item(car(65, 479));
    add_item(car(191, 200));
    add_item(frame(100, 160));
    add_item(car(0, 10));
    add_item(car(128, 10));
    add_item(car(129, 480));
    add_item(car(63, 0));
    add_item(car(127, -1));
    add_item(frame(150, 161));
    add_item(car(192, 5));
    add_item(car(1023, 32767));
    add_item(car(10, -32768));
    add_item(frame(1023, 719));
    add_item(car(63, 479));
    add_item(car(127, 1));
    add_item(car(129, 2));
    add_item(frame(64, 720));
    add_item(frame(128, 2047));
    add_item(frame(191, 400));
    add_item(frame(63, 400));
    wait_idle();

    // phase: random registers, no idling
    write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    write_reg(UnusedReg, $urandom);
    write_all(480 + $urandom_range(400), 600 + $urandom_range(300), $urandom_range(300),
              $urandom_range(200), $urandom, $urandom);
    queue_random(300);
    wait_idle();

    // phase: sender idles
    send_idle_pct = 62;
    queue_random(300);
    wait_idle();

    // phase: receiver stalls, plus a long hold-off while items keep coming
    send_idle_pct = 0; recv_idle_pct = 62;
    queue_random(300);
    fork
      begin
        hold_recv = 1;
        repeat (400) @(posedge clk_i);
        hold_recv = 0;
      end
    join_none
    @(posedge clk_i);
    wait_idle();

    // phase: both sides idle lightly, extreme high registers
    send_idle_pct = 10; recv_idle_pct = 10;
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(300);
    wait_idle();

    // phase: extreme low registers
    send_idle_pct = 0; recv_idle_pct = 0;
    write_all(0, 0, 0, 0, 0, 0);
    queue_random(200);
    wait_idle();

    // phase: sender pauses mid-stream until all results are in
    write_all(32767, 1200, 100, 65535, 65535, 65535);
    send_idle_pct = 62; recv_idle_pct = 62;
    queue_random(300);
    repeat (200) @(posedge clk_i);
    hold_send = 1;
    while (expected_decisions.size() > 0 || in_if.valid) @(posedge clk_i);
    hold_send = 0;
    wait_idle();

    // phase: default-like registers, mixed idling
    write_all(480, 720, 160, 91, 6554, 62259);
    send_idle_pct = 30; recv_idle_pct = 30;
    queue_random(300);
    wait_idle();

    $display("covered %0d car reports and %0d frames, %0d results checked",
             cars_seen, frames_seen, results_seen);
    $display("register sets: reset, random, all ones, all zeros, max gains");
    if (errors == 0) begin
      $display("q_learning_lane_agent_top test passed");
    end else begin
      $display("q_learning_lane_agent_top test failed");
    end
    $finish;
  end

endmodule
